// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lcdn_pkg.sv =====
package lcdn_pkg;

    localparam logic [7:0] EVT_HOLD_MS   = 8'd1;
    localparam logic [7:0] CLEAR_HOLD_MS = 8'd11;
    localparam logic [7:0] INIT_IDLE_MS  = 8'd150;
    localparam logic [7:0] ROW2_BASE     = 8'hC0;
    localparam logic [7:0] DDRAM_CMD     = 8'h80;
    localparam logic [1:0] LAST_PHASE    = 2'd3;

    typedef enum logic [1:0] {
        MODE_CHAR   = 2'd0,
        MODE_CURSOR = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_INIT   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        SRC_CHAR   = 2'd0,
        SRC_CURSOR = 2'd1,
        SRC_CONST  = 2'd2
    } src_t;

    typedef struct packed {
        logic       idle;
        src_t       src;
        logic [7:0] const_byte;
        logic       rs;
        logic       long_tail;
        logic       fin;
        logic       jmp;
        logic [2:0] target;
    } uword_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       row;
        logic [5:0] column;
    } req_t;

    typedef struct packed {
        logic       vld;
        uword_t     word;
        logic [1:0] phase;
    } seq_ctl_t;

    localparam logic [2:0] UA_CLEAR = 3'd2;

    // Microcode: entry address equals the mode code.
    function automatic uword_t ucode(input logic [2:0] addr);
        uword_t w;
        w = '{idle: 1'b0, src: SRC_CONST, const_byte: 8'h00, rs: 1'b0,
              long_tail: 1'b0, fin: 1'b0, jmp: 1'b0, target: 3'd0};
        case (addr)
            3'd0:
            begin
                w.src = SRC_CHAR;
                w.rs  = 1'b1;
                w.fin = 1'b1;
            end
            3'd1:
            begin
                w.src = SRC_CURSOR;
                w.fin = 1'b1;
            end
            3'd2:
            begin
                w.const_byte = 8'h01;
                w.long_tail  = 1'b1;
                w.fin        = 1'b1;
            end
            3'd3:
            begin
                w.idle = 1'b1;
            end
            3'd4:    w.const_byte = 8'h33;
            3'd5:    w.const_byte = 8'h32;
            3'd6:    w.const_byte = 8'h28;
            3'd7:
            begin
                w.const_byte = 8'h0C;
                w.jmp        = 1'b1;
                w.target     = UA_CLEAR;
            end
            default: w.fin = 1'b1;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/lcdn_if.sv =====
interface lcdn_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] char_code;
    logic       row;
    logic [5:0] column;

    modport source (output valid, mode, char_code, row, column, input ready);
    modport sink   (input valid, mode, char_code, row, column, output ready);
endinterface

interface lcdn_evt_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic       enable;
    logic [3:0] nibble;
    logic [7:0] hold_ms;
    logic       last;

    modport source (output valid, reg_select, enable, nibble, hold_ms, last, input ready);
    modport sink   (input valid, reg_select, enable, nibble, hold_ms, last, output ready);
endinterface

// ===== sv/lcdn_seq.sv =====
module lcdn_seq
    import lcdn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lcdn_req_if.sink  req,
    input  logic      take,
    output seq_ctl_t  ctl,
    output req_t      fields
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] pc_reg, pc_next;
    logic [1:0] phase_reg, phase_next;
    req_t       req_reg, req_next;
    uword_t     word;
    logic       evt_end;

    assign word      = ucode(pc_reg);
    assign evt_end   = word.idle || (phase_reg == LAST_PHASE);
    assign req.ready = (state_reg == ST_IDLE);
    assign ctl       = '{vld: (state_reg == ST_RUN), word: word, phase: phase_reg};
    assign fields    = req_reg;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        phase_next = phase_reg;
        req_next   = req_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_RUN;
                    pc_next    = {1'b0, req.mode};
                    phase_next = 2'd0;
                    req_next   = '{char_code: req.char_code, row: req.row,
                                   column: req.column};
                end
            end
            ST_RUN:
            begin
                if (take)
                begin
                    if (evt_end)
                    begin
                        phase_next = 2'd0;
                        if (word.fin)
                            state_next = ST_IDLE;
                        else if (word.jmp)
                            pc_next = word.target;
                        else
                            pc_next = pc_reg + 3'd1;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= 3'd0;
            phase_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

endmodule

// ===== sv/lcdn_datapath.sv =====
module lcdn_datapath
    import lcdn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  seq_ctl_t   ctl,
    input  req_t       fields,
    output logic       take,
    lcdn_evt_if.source evt
);

    logic       vld_reg, vld_next;
    logic       rs_reg, rs_next;
    logic       en_reg, en_next;
    logic [3:0] nib_reg, nib_next;
    logic [7:0] hold_reg, hold_next;
    logic       last_reg, last_next;
    logic [7:0] cursor_byte;
    logic [7:0] byte_sel;
    logic       evt_end;

    assign cursor_byte = ((ROW2_BASE & {8{fields.row}}) + {2'b00, fields.column})
                         | DDRAM_CMD;
    assign evt_end     = ctl.word.idle || (ctl.phase == LAST_PHASE);
    assign take        = !vld_reg || evt.ready;

    always_comb
    begin
        case (ctl.word.src)
            SRC_CHAR:   byte_sel = fields.char_code;
            SRC_CURSOR: byte_sel = cursor_byte;
            default:    byte_sel = ctl.word.const_byte;
        endcase
    end

    always_comb
    begin
        vld_next  = vld_reg && !evt.ready;
        rs_next   = rs_reg;
        en_next   = en_reg;
        nib_next  = nib_reg;
        hold_next = hold_reg;
        last_next = last_reg;
        if (take && ctl.vld)
        begin
            vld_next  = 1'b1;
            last_next = ctl.word.fin && evt_end;
            if (ctl.word.idle)
            begin
                rs_next   = 1'b0;
                en_next   = 1'b0;
                nib_next  = 4'h0;
                hold_next = INIT_IDLE_MS;
            end
            else
            begin
                rs_next   = ctl.word.rs;
                en_next   = !ctl.phase[0];
                nib_next  = ctl.phase[1] ? byte_sel[3:0] : byte_sel[7:4];
                hold_next = (ctl.word.long_tail && evt_end) ? CLEAR_HOLD_MS : EVT_HOLD_MS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        rs_reg   <= rs_next;
        en_reg   <= en_next;
        nib_reg  <= nib_next;
        hold_reg <= hold_next;
        last_reg <= last_next;
    end

    assign evt.valid      = vld_reg;
    assign evt.reg_select = rs_reg;
    assign evt.enable     = en_reg;
    assign evt.nibble     = nib_reg;
    assign evt.hold_ms    = hold_reg;
    assign evt.last       = last_reg;

endmodule

// ===== sv/char_lcd_nibble_write_sequencer.sv =====
// Character LCD write sequencer for a 4-bit bus.
// req carries one request: mode 0 writes char_code to the data register,
// mode 1 moves the cursor to row/column, mode 2 clears the display and
// mode 3 runs the power-up initialisation.
// evt carries one item per pin event: RS, E, D4..D7, a hold time in ms and
// a last flag on the final event of the request.
// A request is taken only while the sequencer is idle, which it can be while
// the last event of the previous request still waits on evt. The first event
// is registered once the sequencer runs; after that one event per cycle while
// the receiver takes them. Modes 0 to 2 give 4 events; initialisation gives
// 21 events. The microcode program sets these counts: each word gives one
// event per phase, and the idle word of initialisation gives a single event.
// Reset empties the output register and returns the sequencer to idle.
// A stall on evt holds the waiting event and freezes the program.
module char_lcd_nibble_write_sequencer
    import lcdn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lcdn_req_if.sink   req,
    lcdn_evt_if.source evt
);

    `include "assert_macros.svh"

    seq_ctl_t ctl;
    req_t     fields;
    logic     take;

    lcdn_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .take   (take),
        .ctl    (ctl),
        .fields (fields)
    );

    lcdn_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .fields (fields),
        .take   (take),
        .evt    (evt)
    );

    `ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
    `ASSERT_SAME(a_idle_pins, evt.valid && evt.hold_ms == INIT_IDLE_MS, !evt.enable && evt.nibble == 4'h0, "idle event pins")
    `ASSERT_SAME(a_strobe_short, evt.valid && evt.enable, evt.hold_ms == EVT_HOLD_MS, "long hold on strobe")
    `ASSERT_SAME(a_no_evt_idle, req.ready, !ctl.vld, "program running while idle")

endmodule
